@@ rtl/oma_pkg.sv @@
`default_nettype none

package oma_pkg;

    // component geometry
    localparam int CW    = 8;
    localparam int NCOMP = 8;
    localparam int IW    = $clog2(NCOMP);
    localparam int PW    = 64;

    // modulus and barrett reduction widths
    localparam int MW    = 9;
    localparam int XW    = 16;
    localparam int MUW   = XW + 1;
    localparam int QW    = XW;
    localparam int RW    = MW + 1;
    localparam int CNTW  = $clog2(NCOMP * NCOMP);
    localparam int DIVW  = $clog2(MUW);

    localparam logic [7:0]     MODULUS_RESET = 8'd251;
    localparam logic [MW-1:0]  M_FOR_ZERO    = MW'(256);
    localparam logic [MUW-1:0] MU_RESET      = MUW'((1 << XW) / 251);

    // opcodes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SCALE = 2'd1,
        OP_MUL   = 2'd2,
        OP_POW   = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_NEXT,
        ST_DONE
    } state_t;

    // bookkeeping that travels with each partial product
    typedef struct packed {
        logic          first;
        logic          last;
        logic          minus;
        logic [IW-1:0] comp;
    } pp_tag_t;

    // b component used for result component i and a component j
    localparam logic [IW-1:0] B_OF [0:NCOMP-1][0:NCOMP-1] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd1, 3'd0, 3'd4, 3'd7, 3'd2, 3'd6, 3'd5, 3'd3},
        '{3'd2, 3'd4, 3'd0, 3'd5, 3'd1, 3'd3, 3'd7, 3'd6},
        '{3'd3, 3'd7, 3'd5, 3'd0, 3'd6, 3'd2, 3'd4, 3'd1},
        '{3'd4, 3'd2, 3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd5},
        '{3'd5, 3'd6, 3'd3, 3'd2, 3'd7, 3'd0, 3'd1, 3'd4},
        '{3'd6, 3'd5, 3'd7, 3'd4, 3'd3, 3'd1, 3'd0, 3'd2},
        '{3'd7, 3'd3, 3'd6, 3'd1, 3'd5, 3'd4, 3'd2, 3'd0}
    };

    // bit j of row i set when that term is subtracted
    localparam logic [NCOMP-1:0] MINUS_OF [0:NCOMP-1] = '{
        8'b1111_1110,
        8'b1101_0000,
        8'b1010_0010,
        8'b0100_0110,
        8'b1000_1100,
        8'b0001_1010,
        8'b0011_0100,
        8'b0110_1000
    };

endpackage

`default_nettype wire

@@ rtl/octonion_modular_alu.sv @@
// Octonion ALU over the integers mod m, eight 8-bit components per operand.
// Requests: raise start with opcode, a_packed, b_packed and factor; the request
// is taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown. The result appears on result_packed for one
// cycle, marked by done; the receiver cannot stall it.
// Opcode add and scalar multiply pass eight component terms through the unit;
// octonion multiply issues 64 partial products one per cycle into a
// four-stage barrett multiply-reduce unit, then drains it and shows the result;
// power runs one octonion multiply pass per exponent step beyond one;
// exponents zero and one show the result in the cycle after the request.
// busy falls in the cycle after done, so the next request can be taken then.
// All passes share the single multiply-reduce unit.
// Configuration: cfg_we with cfg_wdata writes the modulus (zero means 256);
// busy is then high while the reciprocal of m is rebuilt by a
// bit-serial divider. One request is worked on at a time.
// Reset: modulus returns to 251 with its reciprocal ready, the sequencer idles.
`default_nettype none

module octonion_modular_alu
    import oma_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    opcode,
    input  wire logic [PW-1:0] a_packed,
    input  wire logic [PW-1:0] b_packed,
    input  wire logic [7:0]    factor,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata,
    output logic               done,
    output logic [PW-1:0]      result_packed
);

    state_t            state_reg;
    state_t            state_next;
    logic [7:0]        modulus_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [7:0]        pow_left_reg;
    logic              add_mode_reg;
    logic              long_reg;
    logic [CW-1:0]     opa_reg [NCOMP];
    logic [CW-1:0]     opb_reg [NCOMP];
    logic [CW-1:0]     res_reg [NCOMP];
    logic [MW-1:0]     acc_reg;

    logic              accept;
    logic              last_issue;
    logic              pass_done;
    logic              unit_valid;
    logic [MW-1:0]     m_eff;
    logic              recip_busy;
    logic [MUW-1:0]    mu;
    logic [IW-1:0]     idx_i;
    logic [IW-1:0]     idx_j;
    logic [IW-1:0]     idx_b;
    pp_tag_t           issue_tag;
    logic              wb_valid;
    logic [MW-1:0]     wb_p;
    pp_tag_t           wb_tag;
    logic [MW-1:0]     term;
    logic [RW-1:0]     sum;
    logic [MW-1:0]     acc_next;
    logic [NCOMP*CW-1:0] res_flat;
    op_t               op;

    // effective modulus
    assign m_eff  = (modulus_reg == '0) ? M_FOR_ZERO : MW'(modulus_reg);
    assign op     = op_t'(opcode);
    assign busy   = (state_reg != ST_IDLE) || recip_busy || cfg_we;
    assign accept = start && !busy;

    // reciprocal follows the stored modulus
    oma_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cfg_we),
        .m     (m_eff),
        .busy  (recip_busy),
        .mu    (mu)
    );

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // issue indices: result component i, a component j
    always_comb
    begin
        idx_i            = long_reg ? cnt_reg[CNTW-1:IW] : cnt_reg[IW-1:0];
        idx_j            = cnt_reg[IW-1:0];
        idx_b            = long_reg ? B_OF[idx_i][idx_j] : idx_j;
        issue_tag.first  = !long_reg || (idx_j == '0);
        issue_tag.last   = !long_reg || (idx_j == IW'(NCOMP - 1));
        issue_tag.minus  = long_reg && MINUS_OF[idx_i][idx_j];
        issue_tag.comp   = idx_i;
        last_issue       = long_reg ? (cnt_reg == CNTW'(NCOMP * NCOMP - 1))
                                    : (cnt_reg == CNTW'(NCOMP - 1));
    end

    oma_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (unit_valid),
        .add_mode  (add_mode_reg),
        .opnd_a    (opa_reg[idx_j]),
        .opnd_b    (opb_reg[idx_b]),
        .in_tag    (issue_tag),
        .m         (m_eff),
        .mu        (mu),
        .out_valid (wb_valid),
        .residue   (wb_p),
        .out_tag   (wb_tag)
    );

    // signed accumulate mod m
    always_comb
    begin
        term      = wb_tag.minus ? (m_eff - wb_p) : wb_p;
        sum       = (wb_tag.first ? RW'(0) : RW'(acc_reg)) + RW'(term);
        acc_next  = (sum >= RW'(m_eff)) ? MW'(sum - RW'(m_eff)) : MW'(sum);
        pass_done = wb_valid && wb_tag.last && (wb_tag.comp == IW'(NCOMP - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_POW && factor <= 8'd1)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pass_done)
                begin
                    state_next = (pow_left_reg != '0) ? ST_NEXT : ST_DONE;
                end
            end
            ST_NEXT:
            begin
                state_next = ST_RUN;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        unit_valid = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_RUN:   unit_valid = 1'b1;
            ST_DONE:  done       = 1'b1;
            default:
            begin
                unit_valid = 1'b0;
                done       = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pow_left_reg <= '0;
            add_mode_reg <= 1'b0;
            long_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg      <= '0;
                add_mode_reg <= (op == OP_ADD);
                long_reg     <= (op == OP_MUL) || (op == OP_POW);
                pow_left_reg <= (op == OP_POW && factor >= 8'd2) ? (factor - 8'd2) : 8'd0;
            end
            else if (state_reg == ST_RUN)
            begin
                cnt_reg <= last_issue ? CNTW'(0) : (cnt_reg + CNTW'(1));
            end
            else if (state_reg == ST_NEXT)
            begin
                pow_left_reg <= pow_left_reg - 8'd1;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < NCOMP; k++)
            begin
                opa_reg[k] <= a_packed[k*CW +: CW];
                unique case (op)
                    OP_SCALE: opb_reg[k] <= CW'(factor);
                    OP_POW:   opb_reg[k] <= a_packed[k*CW +: CW];
                    default:  opb_reg[k] <= b_packed[k*CW +: CW];
                endcase
                // exponent zero gives the unit octonion
                if (op == OP_POW && factor == 8'd0)
                begin
                    if (k == 0 && m_eff != MW'(1))
                    begin
                        res_reg[k] <= CW'(1);
                    end
                    else
                    begin
                        res_reg[k] <= '0;
                    end
                end
                else if (op == OP_POW && factor == 8'd1)
                begin
                    res_reg[k] <= a_packed[k*CW +: CW];
                end
            end
        end
        else
        begin
            if (state_reg == ST_NEXT)
            begin
                for (int k = 0; k < NCOMP; k++)
                begin
                    opa_reg[k] <= res_reg[k];
                end
            end
            if (wb_valid)
            begin
                acc_reg <= acc_next;
                if (wb_tag.last)
                begin
                    res_reg[wb_tag.comp] <= acc_next[CW-1:0];
                end
            end
        end
    end

    // result packing
    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
        begin
            res_flat[k*CW +: CW] = res_reg[k];
        end
    end

    assign result_packed = PW'(res_flat);

    // a result is shown for one cycle only
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // partial products come back only while a pass is under way
    a_wb_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("partial product outside a pass");

endmodule

`default_nettype wire

@@ rtl/oma_recip.sv @@
`default_nettype none

module oma_recip
    import oma_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire logic [MW-1:0]  m,
    output logic                busy,
    output logic [MUW-1:0]      mu
);

    logic            run_reg;
    logic [DIVW-1:0] cnt_reg;
    logic [MW-1:0]   rem_reg;
    logic [MUW-1:0]  mu_reg;

    logic            dbit;
    logic [RW-1:0]   trial;
    logic            qbit;
    logic [RW-1:0]   rem_next;

    // one quotient bit of 2^XW / m per cycle
    always_comb
    begin
        dbit     = (cnt_reg == DIVW'(XW));
        trial    = {rem_reg, dbit};
        qbit     = (trial >= RW'(m));
        rem_next = qbit ? (trial - RW'(m)) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            mu_reg  <= MU_RESET;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            cnt_reg <= DIVW'(XW);
            rem_reg <= '0;
            mu_reg  <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next[MW-1:0];
            mu_reg  <= {mu_reg[MUW-2:0], qbit};
            cnt_reg <= cnt_reg - DIVW'(1);
            if (cnt_reg == '0)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    assign busy = run_reg;
    assign mu   = mu_reg;

    // finished quotient is the floor of 2^XW / m
    a_mu_floor: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(run_reg) |->
            ((26'(mu_reg) * 26'(m) <= 26'(1 << XW)) &&
             ((26'(mu_reg) + 26'd1) * 26'(m) > 26'(1 << XW))))
        else $error("reciprocal out of range");

endmodule

`default_nettype wire

@@ rtl/oma_modmul.sv @@
`default_nettype none

module oma_modmul
    import oma_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           add_mode,
    input  wire logic [CW-1:0]  opnd_a,
    input  wire logic [CW-1:0]  opnd_b,
    input  wire pp_tag_t        in_tag,
    input  wire logic [MW-1:0]  m,
    input  wire logic [MUW-1:0] mu,
    output logic                out_valid,
    output logic [MW-1:0]       residue,
    output pp_tag_t             out_tag
);

    logic                s1_valid_reg;
    logic [XW-1:0]       s1_x_reg;
    pp_tag_t             s1_tag_reg;
    logic                s2_valid_reg;
    logic [XW-1:0]       s2_x_reg;
    logic [QW-1:0]       s2_q_reg;
    pp_tag_t             s2_tag_reg;
    logic                s3_valid_reg;
    logic [RW-1:0]       s3_r_reg;
    pp_tag_t             s3_tag_reg;
    logic                out_valid_reg;
    logic [MW-1:0]       residue_reg;
    pp_tag_t             out_tag_reg;

    logic [XW-1:0]       x_next;
    logic [XW+MUW-1:0]   prod_mu;
    logic [QW+MW-1:0]    qm;
    logic [QW+MW-1:0]    diff;
    logic [MW-1:0]       residue_next;

    // stage 1 raw value, stage 2 quotient estimate, stage 3 remainder, then one correction
    always_comb
    begin
        x_next       = add_mode ? (XW'(opnd_a) + XW'(opnd_b)) : (XW'(opnd_a) * XW'(opnd_b));
        prod_mu      = (XW+MUW)'(s1_x_reg) * (XW+MUW)'(mu);
        qm           = (QW+MW)'(s2_q_reg) * (QW+MW)'(m);
        diff         = (QW+MW)'(s2_x_reg) - qm;
        residue_next = (s3_r_reg >= RW'(m)) ? MW'(s3_r_reg - RW'(m)) : MW'(s3_r_reg);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        s1_x_reg    <= x_next;
        s1_tag_reg  <= in_tag;
        s2_x_reg    <= s1_x_reg;
        s2_q_reg    <= prod_mu[XW+QW-1:XW];
        s2_tag_reg  <= s1_tag_reg;
        s3_r_reg    <= diff[RW-1:0];
        s3_tag_reg  <= s2_tag_reg;
        residue_reg <= residue_next;
        out_tag_reg <= s3_tag_reg;
    end

    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;
    assign out_tag   = out_tag_reg;

    // every output has a matching input through the stage registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 4))
        else $error("modmul output without matching input");

endmodule

`default_nettype wire
